// File: rtl/core/opa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octant pseudo-angle package
// Widths, the pi/4 scale constant, octant numbers and the sideband type
// shared by the pipeline modules.
// ----------------------------------------------------------------------------
package opa_pkg;

	// Input component width and fraction width of the in-octant ratio.
	localparam int IN_WIDTH  = 16;
	localparam int FRAC_BITS = 14;

	// A magnitude reaches 2^(IN_WIDTH-1), which still fits in IN_WIDTH bits.
	localparam int MAG_W = IN_WIDTH;

	// The quotient runs from 0 to 2^FRAC_BITS inclusive.
	localparam int QUOT_W     = FRAC_BITS + 1;
	localparam int DIV_STAGES = QUOT_W;

	// Octant number, plus one, above the fraction.
	localparam int OCT_W = 3;
	localparam int SUM_W = OCT_W + 1 + FRAC_BITS;

	// pi/4 in Q0.15 and the output format.
	localparam int                QPI_W      = 15;
	localparam logic [QPI_W-1:0]  QUARTER_PI = QPI_W'(25736);
	localparam int                OUT_W      = 16;
	localparam int                PROD_W     = SUM_W + QPI_W;
	localparam int                OUT_SHIFT  = FRAC_BITS + 2;

	// Octants, counter-clockwise from the positive x axis.
	localparam logic [OCT_W-1:0] OCT_E_NE = 3'd0;
	localparam logic [OCT_W-1:0] OCT_NE_N = 3'd1;
	localparam logic [OCT_W-1:0] OCT_N_NW = 3'd2;
	localparam logic [OCT_W-1:0] OCT_NW_W = 3'd3;
	localparam logic [OCT_W-1:0] OCT_W_SW = 3'd4;
	localparam logic [OCT_W-1:0] OCT_SW_S = 3'd5;
	localparam logic [OCT_W-1:0] OCT_S_SE = 3'd6;
	localparam logic [OCT_W-1:0] OCT_SE_E = 3'd7;

	// Information that travels alongside the divider.
	typedef struct packed {
		logic [OCT_W-1:0] octant;
		logic             on_axis;
	} opa_side_t;

endpackage

// File: rtl/core/opa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octant pseudo-angle channels
// Valid/ready channels for the input vector and for the resulting angle.
// ----------------------------------------------------------------------------

// Input vector channel.
interface opa_vec_if import opa_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [IN_WIDTH-1:0] vec_x;
	logic signed [IN_WIDTH-1:0] vec_y;

	modport source (output valid, output vec_x, output vec_y, input ready);
	modport sink (input valid, input vec_x, input vec_y, output ready);
endinterface

// Result angle channel.
interface opa_ang_if import opa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] angle;

	modport source (output valid, output angle, input ready);
	modport sink (input valid, input angle, output ready);
endinterface

// File: rtl/core/opa_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octant pseudo-angle ratio divider
// Restoring divider, one quotient bit per pipeline stage, that forms
// floor((small << FRAC_BITS) / large) for small <= large.
// ----------------------------------------------------------------------------
module opa_div_pipe import opa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                op_valid,
	output logic                op_ready,
	input  logic [MAG_W-1:0]    op_small,
	input  logic [MAG_W-1:0]    op_large,
	input  opa_side_t           op_side,
	output logic                res_valid,
	input  logic                res_ready,
	output logic [QUOT_W-1:0]   res_quot,
	output opa_side_t           res_side
);

	// Stage registers, one entry per quotient bit.
	logic                valid_s [DIV_STAGES];
	logic [MAG_W-1:0]    rem_s   [DIV_STAGES];
	logic [MAG_W-1:0]    large_s [DIV_STAGES];
	logic [QUOT_W-1:0]   quot_s  [DIV_STAGES];
	opa_side_t           side_s  [DIV_STAGES];

	// Stage inputs and the ready chain.
	logic                valid_in [DIV_STAGES];
	logic [MAG_W-1:0]    rem_in   [DIV_STAGES];
	logic [MAG_W-1:0]    large_in [DIV_STAGES];
	logic [QUOT_W-1:0]   quot_in  [DIV_STAGES];
	opa_side_t           side_in  [DIV_STAGES];
	logic                rdy      [DIV_STAGES+1];

	assign rdy[DIV_STAGES] = res_ready;
	assign op_ready        = rdy[0];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [MAG_W:0]   trial;
		logic [MAG_W:0]   diff;
		logic             ge;
		logic [MAG_W-1:0] rem_next;

		// Feed from the port for the first stage, else from the stage before.
		if (k == 0) begin : g_first
			assign valid_in[k] = op_valid;
			assign rem_in[k]   = op_small;
			assign large_in[k] = op_large;
			assign quot_in[k]  = '0;
			assign side_in[k]  = op_side;
			// The leading bit weighs the ratio's whole unit: no shift.
			assign trial = {1'b0, rem_in[k]};
		end else begin : g_next
			assign valid_in[k] = valid_s[k-1];
			assign rem_in[k]   = rem_s[k-1];
			assign large_in[k] = large_s[k-1];
			assign quot_in[k]  = quot_s[k-1];
			assign side_in[k]  = side_s[k-1];
			assign trial = {rem_in[k], 1'b0};
		end

		// One trial subtraction decides this quotient bit.
		assign diff     = trial - {1'b0, large_in[k]};
		assign ge       = trial >= {1'b0, large_in[k]};
		assign rem_next = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];

		// A stage may take a word when empty or when its word moves on.
		assign rdy[k] = !valid_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				valid_s[k] <= valid_in[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && valid_in[k]) begin
				rem_s[k]   <= rem_next;
				large_s[k] <= large_in[k];
				quot_s[k]  <= {quot_in[k][QUOT_W-2:0], ge};
				side_s[k]  <= side_in[k];
			end
		end
	end

	assign res_valid = valid_s[DIV_STAGES-1];
	assign res_quot  = quot_s[DIV_STAGES-1];
	assign res_side  = side_s[DIV_STAGES-1];

endmodule

// File: rtl/core/octant_pseudo_angle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octant pseudo-angle
// Monotonic octant-linear angle of a signed vector, unsigned Q3.13 radians.
// ----------------------------------------------------------------------------
// The block takes one vector word per clock while the result is not held,
// and returns one angle word per vector, in order. The ratio divider
// resolves one quotient bit per pipeline stage (FRAC_BITS + 1 stages);
// there are two stages in front of it for magnitudes and octant selection
// and two behind it for the octant offset and the pi/4 scaling multiply.
// Back-pressure on the result stalls the pipeline stage by stage without
// losing or repeating any word; bubbles are closed up as words advance.
// Vectors on an axis, and the zero vector, give exact multiples of pi/2
// (the zero vector gives 0).
// ----------------------------------------------------------------------------
module octant_pseudo_angle import opa_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	opa_vec_if.sink      sample,
	opa_ang_if.source    result
);

	// Stage 1: magnitudes, signs and zero flags.
	logic               valid_s1;
	logic [MAG_W-1:0]   ax_s1;
	logic [MAG_W-1:0]   ay_s1;
	logic               xneg_s1;
	logic               yneg_s1;
	logic               xzero_s1;
	logic               yzero_s1;
	logic               ready_s1;

	// Stage 2: ordered magnitudes and octant.
	logic               valid_s2;
	logic [MAG_W-1:0]   small_s2;
	logic [MAG_W-1:0]   large_s2;
	opa_side_t          side_s2;
	logic               ready_s2;

	// Divider output.
	logic               div_ready;
	logic               div_valid;
	logic [QUOT_W-1:0]  div_quot;
	opa_side_t          div_side;

	// Stage 3: octant plus fraction.
	logic               valid_s3;
	logic [SUM_W-1:0]   sum_s3;
	logic               ready_s3;

	// Stage 4: scaled angle.
	logic               valid_s4;
	logic [OUT_W-1:0]   angle_s4;
	logic               ready_s4;

	logic [MAG_W-1:0]   xu;
	logic [MAG_W-1:0]   yu;
	logic               xbig;
	logic [OCT_W-1:0]   octant;
	logic [OCT_W:0]     oct_next;
	logic [SUM_W-1:0]   sum_next;
	logic [PROD_W-1:0]  prod;

	assign ready_s1     = !valid_s1 || ready_s2;
	assign ready_s2     = !valid_s2 || div_ready;
	assign ready_s3     = !valid_s3 || ready_s4;
	assign ready_s4     = !valid_s4 || result.ready;
	assign sample.ready = ready_s1;

	// Magnitudes in two's complement; the most negative value maps exactly.
	assign xu = MAG_W'(sample.vec_x);
	assign yu = MAG_W'(sample.vec_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && sample.valid) begin
			xneg_s1  <= xu[MAG_W-1];
			yneg_s1  <= yu[MAG_W-1];
			ax_s1    <= xu[MAG_W-1] ? (~xu + 1'b1) : xu;
			ay_s1    <= yu[MAG_W-1] ? (~yu + 1'b1) : yu;
			xzero_s1 <= (xu == '0);
			yzero_s1 <= (yu == '0);
		end
	end

	// Octant choice. On an axis the octant is the even one that starts at
	// that axis and the fraction is forced to zero later on.
	assign xbig = ax_s1 > ay_s1;

	always_comb begin
		if (xzero_s1) begin
			if (yzero_s1) begin
				octant = OCT_E_NE;
			end else if (!yneg_s1) begin
				octant = OCT_N_NW;
			end else begin
				octant = OCT_S_SE;
			end
		end else if (yzero_s1) begin
			octant = xneg_s1 ? OCT_W_SW : OCT_E_NE;
		end else begin
			case ({xneg_s1, yneg_s1})
				2'b00:   octant = xbig ? OCT_E_NE : OCT_NE_N;
				2'b10:   octant = xbig ? OCT_NW_W : OCT_N_NW;
				2'b11:   octant = xbig ? OCT_W_SW : OCT_SW_S;
				default: octant = xbig ? OCT_SE_E : OCT_S_SE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			small_s2        <= xbig ? ay_s1 : ax_s1;
			large_s2        <= xbig ? ax_s1 : ay_s1;
			side_s2.octant  <= octant;
			side_s2.on_axis <= xzero_s1 || yzero_s1;
		end
	end

	// Ratio of the smaller magnitude to the larger.
	opa_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (valid_s2),
		.op_ready  (div_ready),
		.op_small  (small_s2),
		.op_large  (large_s2),
		.op_side   (side_s2),
		.res_valid (div_valid),
		.res_ready (ready_s3),
		.res_quot  (div_quot),
		.res_side  (div_side)
	);

	// Odd octants count down from the next octant's start, even ones up.
	assign oct_next = {1'b0, div_side.octant} + 1'b1;

	always_comb begin
		if (div_side.on_axis) begin
			sum_next = {1'b0, div_side.octant, {FRAC_BITS{1'b0}}};
		end else if (div_side.octant[0]) begin
			sum_next = {oct_next, {FRAC_BITS{1'b0}}} - SUM_W'(div_quot);
		end else begin
			sum_next = {1'b0, div_side.octant, {FRAC_BITS{1'b0}}} + SUM_W'(div_quot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && div_valid) begin
			sum_s3 <= sum_next;
		end
	end

	// Scale by pi/4 into Q3.13.
	assign prod = PROD_W'(sum_s3) * PROD_W'(QUARTER_PI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			angle_s4 <= prod[OUT_SHIFT +: OUT_W];
		end
	end

	assign result.valid = valid_s4;
	assign result.angle = angle_s4;

endmodule

// File: test/tb_octant_pseudo_angle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octant pseudo-angle testbench
// A directed table covers the axes, the diagonals, every octant and the
// extreme inputs. Random vectors follow, weighted towards near-diagonal,
// steep, on-axis and full-scale cases. Both channels idle in short random
// bursts. Each angle word is checked, in order, against the table's angle
// where known, else against a local model of the octant-linear angle.
// ----------------------------------------------------------------------------
module tb_octant_pseudo_angle import opa_pkg::*; ();

	localparam int DIRECTED_ITEMS = 26;
	localparam int RANDOM_ITEMS   = 424;
	localparam int QUIET_ITEMS    = 60;
	localparam int DRAIN_CYCLES   = 40;
	localparam int CYCLE_LIMIT    = 50000;

	// One row of the directed table: a vector and, where known, its angle.
	typedef struct packed {
		logic signed [IN_WIDTH-1:0] x;
		logic signed [IN_WIDTH-1:0] y;
		logic                       known;
		logic [OUT_W-1:0]           angle;
	} probe_t;

	localparam probe_t DIRECTED [DIRECTED_ITEMS] = '{
		// Zero vector and the four axes.
		'{0, 0, 1'b1, 0},
		'{0, 1, 1'b1, 12868},
		'{0, -1, 1'b1, 38604},
		'{1, 0, 1'b1, 0},
		'{-1, 0, 1'b1, 25736},
		'{0, 32767, 1'b1, 12868},
		'{0, 16'h8000, 1'b1, 38604},
		'{16'h8000, 0, 1'b1, 25736},
		// Equal magnitudes sit exactly on the diagonals.
		'{100, 100, 1'b1, 6434},
		'{-100, 100, 1'b1, 19302},
		'{-100, -100, 1'b1, 32170},
		'{100, -100, 1'b1, 45038},
		'{16'h8000, 16'h8000, 1'b1, 32170},
		// Ratios that truncate to zero at full scale.
		'{32767, -1, 1'b1, 51472},
		'{32767, 1, 1'b1, 0},
		'{1, 16'h8000, 1'b1, 38604},
		// One vector inside each octant, counter-clockwise.
		'{300, 200, 1'b0, 0},
		'{200, 300, 1'b0, 0},
		'{-200, 300, 1'b0, 0},
		'{-300, 200, 1'b0, 0},
		'{-300, -200, 1'b0, 0},
		'{-200, -300, 1'b0, 0},
		'{200, -300, 1'b0, 0},
		'{300, -200, 1'b0, 0},
		// Most negative component against the largest positive one.
		'{16'h8000, 32767, 1'b0, 0},
		'{32767, 16'h8000, 1'b0, 0}
	};

	localparam logic signed [IN_WIDTH-1:0] RAIL_VALUES [8] = '{
		16'h8000, 16'h8001, -2, -1, 0, 1, 32766, 32767
	};

	logic clk = 1'b0;
	logic arst_n;
	logic quiet = 1'b0;

	logic [OUT_W-1:0] angles_due[$];
	int               angles_checked = 0;
	int               mismatches     = 0;
	int               cycle_count    = 0;

	opa_vec_if vec_ch ();
	opa_ang_if ang_ch ();

	octant_pseudo_angle dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (vec_ch),
		.result (ang_ch)
	);

	always #5 clk = ~clk;

	// Octant-linear angle of a vector, scaled by pi/4 into Q3.13.
	function automatic logic [OUT_W-1:0] pseudo_angle(input logic signed [IN_WIDTH-1:0] x,
			input logic signed [IN_WIDTH-1:0] y);
		logic [SUM_W-1:0]  one;
		logic [MAG_W-1:0]  ax;
		logic [MAG_W-1:0]  ay;
		logic [MAG_W-1:0]  lesser;
		logic [MAG_W-1:0]  greater;
		logic [QUOT_W-1:0] ratio;
		logic [OCT_W-1:0]  octant;
		logic [SUM_W-1:0]  frac;
		logic [SUM_W-1:0]  s;
		logic [PROD_W-1:0] prod;
		logic              x_wins;
		one = SUM_W'(1) << FRAC_BITS;
		if (x == 0) begin
			if (y == 0)
				s = '0;
			else if (!y[IN_WIDTH-1])
				s = SUM_W'(OCT_N_NW) * one;
			else
				s = SUM_W'(OCT_S_SE) * one;
		end else if (y == 0) begin
			s = x[IN_WIDTH-1] ? SUM_W'(OCT_W_SW) * one : '0;
		end else begin
			ax = x;
			ay = y;
			if (x[IN_WIDTH-1])
				ax = ~ax + 1'b1;
			if (y[IN_WIDTH-1])
				ay = ~ay + 1'b1;
			x_wins  = ax > ay;
			lesser  = x_wins ? ay : ax;
			greater = x_wins ? ax : ay;
			ratio   = QUOT_W'({lesser, FRAC_BITS'(0)} / greater);
			case ({x[IN_WIDTH-1], y[IN_WIDTH-1]})
				2'b00: octant = x_wins ? OCT_E_NE : OCT_NE_N;
				2'b10: octant = x_wins ? OCT_NW_W : OCT_N_NW;
				2'b11: octant = x_wins ? OCT_W_SW : OCT_SW_S;
				default: octant = x_wins ? OCT_SE_E : OCT_S_SE;
			endcase
			// Odd octants run the ratio backwards so the angle keeps rising.
			frac = octant[0] ? one - SUM_W'(ratio) : SUM_W'(ratio);
			s = SUM_W'(octant) * one + frac;
		end
		prod = PROD_W'(s) * PROD_W'(QUARTER_PI);
		return prod[OUT_SHIFT +: OUT_W];
	endfunction

	// Random vector, weighted towards the awkward corners of the input space.
	task automatic pick_vector(output logic signed [IN_WIDTH-1:0] x,
			output logic signed [IN_WIDTH-1:0] y);
		int unsigned                kind;
		int unsigned                a;
		int unsigned                b;
		logic signed [IN_WIDTH-1:0] swap;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2, 3: begin
				x = IN_WIDTH'($urandom);
				y = IN_WIDTH'($urandom);
			end
			4: begin
				a = $urandom_range(0, 8);
				b = $urandom_range(0, 8);
				x = IN_WIDTH'(a - 4);
				y = IN_WIDTH'(b - 4);
			end
			5, 6: begin
				// Near the diagonal: magnitudes differ by at most one.
				a = $urandom_range(1, 32767);
				b = a + $urandom_range(0, 2) - 1;
				x = $urandom_range(0, 1) ? IN_WIDTH'(-a) : IN_WIDTH'(a);
				y = $urandom_range(0, 1) ? IN_WIDTH'(-b) : IN_WIDTH'(b);
			end
			7: begin
				x = IN_WIDTH'($urandom);
				y = '0;
			end
			8: begin
				x = RAIL_VALUES[$urandom_range(0, 7)];
				y = RAIL_VALUES[$urandom_range(0, 7)];
			end
			default: begin
				// Steep: one large component, one tiny.
				a = $urandom_range(0, 6);
				x = IN_WIDTH'($urandom);
				y = IN_WIDTH'(a - 3);
			end
		endcase
		if ($urandom_range(0, 1)) begin
			swap = x;
			x    = y;
			y    = swap;
		end
	endtask

	// Offer one vector word, then queue its expected angle once accepted.
	task automatic send_vector(input logic signed [IN_WIDTH-1:0] x,
			input logic signed [IN_WIDTH-1:0] y, input logic known,
			input logic [OUT_W-1:0] angle);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			vec_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		vec_ch.valid <= 1'b1;
		vec_ch.vec_x <= x;
		vec_ch.vec_y <= y;
		@(posedge clk);
		while (!vec_ch.ready)
			@(posedge clk);
		angles_due.push_back(known ? angle : pseudo_angle(x, y));
	endtask

	// Result side: hold ready low in short random bursts until the quiet tail.
	initial begin
		ang_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				ang_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			ang_ch.ready <= 1'b1;
		end
	end

	// Compare every accepted angle word with the oldest expectation.
	always @(posedge clk) begin : angle_check
		logic [OUT_W-1:0] due;
		if (arst_n && ang_ch.valid && ang_ch.ready) begin
			if (angles_due.size() == 0) begin
				$error("angle: expected nothing, actual %0d", ang_ch.angle);
				mismatches++;
			end else begin
				due = angles_due.pop_front();
				angles_checked++;
				if (ang_ch.angle !== due) begin
					$error("angle: expected %0d, actual %0d", due, ang_ch.angle);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d words outstanding", cycle_count,
				angles_due.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Main sequence: reset, directed table, random vectors, drain.
	initial begin : stimulus
		logic signed [IN_WIDTH-1:0] x;
		logic signed [IN_WIDTH-1:0] y;
		arst_n       = 1'b0;
		vec_ch.valid = 1'b0;
		vec_ch.vec_x = '0;
		vec_ch.vec_y = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ITEMS; i++)
			send_vector(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].known, DIRECTED[i].angle);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i >= RANDOM_ITEMS - QUIET_ITEMS)
				quiet = 1'b1;
			pick_vector(x, y);
			send_vector(x, y, 1'b0, '0);
		end
		vec_ch.valid <= 1'b0;

		while (angles_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d directed and %0d random vectors; %0d angle words checked,",
			DIRECTED_ITEMS, RANDOM_ITEMS, angles_checked);
		$display("with random idling on both channels and a final stretch at full rate.");
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: octant_pseudo_angle.f
rtl/core/opa_pkg.sv
rtl/core/opa_if.sv
rtl/core/opa_div_pipe.sv
rtl/core/octant_pseudo_angle.sv
test/tb_octant_pseudo_angle.sv
